[rtl/core/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and constants of the LRU replacement tracker.
// ----------------------------------------------------------------------------
package lrt_pkg;

  // Width of the page fields and of the capacity register
  localparam int PageW = 16;
  localparam int CapW  = 5;

  // Capacity register value after reset
  localparam logic [CapW-1:0] CapReset = 5'd10;

  // Request kinds
  typedef enum logic [0:0] {
    KindTouch = 1'b0,
    KindEvict = 1'b1
  } lrt_kind_e;

  // Request word as held in the input register
  typedef struct packed {
    lrt_kind_e        kind;
    logic [PageW-1:0] page;
  } lrt_req_t;

  // Result word as held in the output register
  typedef struct packed {
    logic             hit;
    logic             evicted_valid;
    logic [PageW-1:0] evicted_page;
  } lrt_rsp_t;

endpackage

[rtl/core/lrt_in_stage.sv]
// ----------------------------------------------------------------------------
// lrt_in_stage
// Input register: captures one request word and holds it until the
// tracker table consumes it.
// ----------------------------------------------------------------------------
module lrt_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  lrt_pkg::lrt_req_t req_i,
  output logic              valid_o,
  output lrt_pkg::lrt_req_t req_o,
  input  logic              take_i
);

  logic              valid_q, valid_d;
  logic              load;
  lrt_pkg::lrt_req_t req_q;

  // Accept when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until replaced
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

[rtl/core/lrt_table.sv]
// ----------------------------------------------------------------------------
// lrt_table
// Entry table with recency ranks. Compares the request against all live
// entries at once, forms the result and updates pages, ranks and occupancy
// in the same cycle.
// ----------------------------------------------------------------------------
module lrt_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  lrt_pkg::lrt_req_t          req_i,
  input  logic [lrt_pkg::CapW-1:0]   cap_i,
  output lrt_pkg::lrt_rsp_t          rsp_o
);

  localparam int AgeW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OccW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (OccW > lrt_pkg::CapW) ? OccW : lrt_pkg::CapW;

  // Entries live in slots 0..occupancy-1; rank 0 is the most recent
  logic [lrt_pkg::PageW-1:0] page_q [MAX_ENTRIES];
  logic [lrt_pkg::PageW-1:0] page_d [MAX_ENTRIES];
  logic [AgeW-1:0]           age_q  [MAX_ENTRIES];
  logic [AgeW-1:0]           age_d  [MAX_ENTRIES];
  logic [OccW-1:0]           occ_q, occ_d;

  logic [MAX_ENTRIES-1:0]    live;
  logic [MAX_ENTRIES-1:0]    match;
  logic [MAX_ENTRIES-1:0]    is_old;
  logic [MAX_ENTRIES-1:0]    past_hole;
  logic [AgeW-1:0]           oldest_rank;
  logic [AgeW-1:0]           hit_age;
  logic [lrt_pkg::PageW-1:0] old_page;
  logic                      is_touch;
  logic                      hit;
  logic                      full;
  logic                      not_empty;
  logic [CmpW-1:0]           eff_cap;
  logic [CmpW-1:0]           cap_ext;

  assign is_touch    = (req_i.kind == lrt_pkg::KindTouch);
  assign not_empty   = (occ_q != '0);
  assign oldest_rank = AgeW'(occ_q - OccW'(1));

  // Clamp capacity into 1..MAX_ENTRIES
  assign cap_ext = CmpW'(cap_i);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(MAX_ENTRIES)) begin
      eff_cap = CmpW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (CmpW'(occ_q) >= eff_cap);

  // Compare all slots in parallel
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      live[i]   = (OccW'(i) < occ_q);
      match[i]  = live[i] && (page_q[i] == req_i.page);
      is_old[i] = live[i] && (age_q[i] == oldest_rank);
    end
  end

  // Slots at or above the oldest entry; they shift down on an evict
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      past_hole[i] = |(is_old & ({MAX_ENTRIES{1'b1}} >> (MAX_ENTRIES - 1 - i)));
    end
  end

  // Gather rank of the hit entry and page of the oldest entry
  always_comb begin
    hit_age  = '0;
    old_page = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_age  = hit_age  | (match[i]  ? age_q[i]  : '0);
      old_page = old_page | (is_old[i] ? page_q[i] : '0);
    end
  end

  assign hit = is_touch && (|match);

  // Form the result word
  always_comb begin
    rsp_o.hit           = hit;
    rsp_o.evicted_valid = is_touch ? (!hit && full) : not_empty;
    rsp_o.evicted_page  = rsp_o.evicted_valid ? old_page : '0;
  end

  // Next occupancy
  always_comb begin
    occ_d = occ_q;
    if (!is_touch) begin
      if (not_empty) begin
        occ_d = occ_q - OccW'(1);
      end
    end else if (!hit && !full) begin
      occ_d = occ_q + OccW'(1);
    end
  end

  // Next page and rank of each slot
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_slot
    logic [lrt_pkg::PageW-1:0] up_page;
    logic [AgeW-1:0]           up_age;
    logic                      is_new;

    if (g < MAX_ENTRIES - 1) begin : g_up
      assign up_page = page_q[g+1];
      assign up_age  = age_q[g+1];
    end else begin : g_top
      assign up_page = page_q[g];
      assign up_age  = age_q[g];
    end

    assign is_new = (OccW'(g) == occ_q);

    always_comb begin
      page_d[g] = page_q[g];
      age_d[g]  = age_q[g];
      if (!is_touch) begin
        // Close the hole left by the oldest entry
        if (live[g] && past_hole[g]) begin
          page_d[g] = up_page;
          age_d[g]  = up_age;
        end
      end else if (hit) begin
        // Promote the hit entry, age the more recent ones
        if (match[g]) begin
          age_d[g] = '0;
        end else if (live[g] && (age_q[g] < hit_age)) begin
          age_d[g] = age_q[g] + AgeW'(1);
        end
      end else if (full) begin
        // Replace the oldest entry in place
        if (is_old[g]) begin
          page_d[g] = req_i.page;
          age_d[g]  = '0;
        end else if (live[g]) begin
          age_d[g] = age_q[g] + AgeW'(1);
        end
      end else begin
        // Append in the first free slot
        if (is_new) begin
          page_d[g] = req_i.page;
          age_d[g]  = '0;
        end else if (live[g]) begin
          age_d[g] = age_q[g] + AgeW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (step_i) begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        page_q[i] <= page_d[i];
        age_q[i]  <= age_d[i];
      end
    end
  end

endmodule

[rtl/core/lrt_out_stage.sv]
// ----------------------------------------------------------------------------
// lrt_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module lrt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lrt_pkg::lrt_rsp_t rsp_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output lrt_pkg::lrt_rsp_t rsp_o
);

  logic              valid_q, valid_d;
  lrt_pkg::lrt_rsp_t rsp_q;

  // Free when empty or when the held word is taken this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

[rtl/core/lru_replacement_tracker.sv]
// ----------------------------------------------------------------------------
// lru_replacement_tracker
// Tracks page ids in least-recently-used order and reports hits and evictions.
// ----------------------------------------------------------------------------
// The tracker takes one request word per cycle while the result register can
// take its result, and returns exactly one result word per request, in order.
// A request is held in the input register, and stays there as long as a
// result word waits, while all entries are compared against it in parallel.
// Its result enters the output register as the request leaves the input
// register. The parallel compare over all slots is combinational and sets the
// throughput of one word per cycle. A touch makes a tracked page most recent
// or inserts a new one, evicting the least recent page when occupancy has
// reached the capacity register (clamped to 1..MAX_ENTRIES). An evict request
// drains the least recent page, or reports none when empty. Write capacity
// only while idle.
// ----------------------------------------------------------------------------
module lru_replacement_tracker #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [lrt_pkg::PageW-1:0]   page_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic                        evicted_valid_o,
  output logic [lrt_pkg::PageW-1:0]   evicted_page_o,
  input  logic                        cfg_we_i,
  input  logic [lrt_pkg::CapW-1:0]    cfg_wdata_i
);

  lrt_pkg::lrt_req_t          req_in;
  lrt_pkg::lrt_req_t          req_held;
  lrt_pkg::lrt_rsp_t          rsp_next;
  lrt_pkg::lrt_rsp_t          rsp_held;
  logic                       held_valid;
  logic                       out_free;
  logic                       step;
  logic [lrt_pkg::CapW-1:0]   capacity_q;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lrt_pkg::CapReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  assign req_in.kind = lrt_pkg::lrt_kind_e'(kind_i);
  assign req_in.page = page_i;

  // Advance the held request when the result register can take its result
  assign step = held_valid && out_free;

  lrt_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (req_in),
    .valid_o (held_valid),
    .req_o   (req_held),
    .take_i  (step)
  );

  lrt_table #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_held),
    .cap_i  (capacity_q),
    .rsp_o  (rsp_next)
  );

  lrt_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .rsp_i   (rsp_next),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (rsp_held)
  );

  assign hit_o           = rsp_held.hit;
  assign evicted_valid_o = rsp_held.evicted_valid;
  assign evicted_page_o  = rsp_held.evicted_page;

endmodule

[rtl/core/lrt_checker.sv]
// ----------------------------------------------------------------------------
// lrt_checker
// Port-level checks of the LRU replacement tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lrt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      hit_o,
  input logic                      evicted_valid_o,
  input logic [lrt_pkg::PageW-1:0] evicted_page_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hit_o) &&
      $stable(evicted_valid_o) && $stable(evicted_page_o)))
    else $error("stalled result word changed");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> !evicted_valid_o)
    else $error("hit reported together with an eviction");

  // Without an eviction the evicted page reads zero
  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page nonzero without an eviction");

  // Input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the result side is free");

endmodule

bind lru_replacement_tracker lrt_checker u_lrt_checker (.*);
